@@ rtl/rleb_pkg.sv @@
package rleb_pkg;

  localparam int ROWS_W     = 13;
  localparam int COLS_W     = 13;
  localparam int STRIDE_W   = 14;
  localparam int CFG_DATA_W = 24;
  localparam int CFG_IDX_W  = 3;
  localparam int ADDR_W     = 25;
  localparam int LEN_W      = 9;
  localparam int BYTE_W     = 8;

  localparam logic [BYTE_W-1:0] ESC_BYTE     = 8'hFF;
  localparam logic [LEN_W-1:0]  ESC_RUN_BIAS = 9'd2;
  localparam logic [LEN_W-1:0]  RUN_BIAS     = 9'd4;
  localparam logic [LEN_W-1:0]  SINGLE_LEN   = 9'd1;

  typedef enum logic [CFG_IDX_W-1:0] {
    REG_ROWS   = 3'd0,
    REG_COLS   = 3'd1,
    REG_STRIDE = 3'd2,
    REG_BUDGET = 3'd3
  } cfg_reg_t;

  typedef enum logic [1:0] {
    PH_IDLE,
    PH_COUNT,
    PH_VALUE
  } phase_t;

  typedef enum logic [1:0] {
    ERR_NONE   = 2'd0,
    ERR_BUDGET = 2'd1,
    ERR_RUN    = 2'd2
  } err_t;

  typedef struct packed {
    logic [ROWS_W-1:0]   rows;
    logic [COLS_W-1:0]   cols;
    logic [STRIDE_W-1:0] stride;
  } geom_t;

  // one parsed run, or a budget overrun marker
  typedef struct packed {
    logic              budget_err;
    logic [BYTE_W-1:0] value;
    logic [LEN_W-1:0]  len;
  } desc_t;

  typedef struct packed {
    logic [BYTE_W-1:0] pixel_value;
    logic [LEN_W-1:0]  run_length;
    logic [ADDR_W-1:0] start_address;
    logic              row_done;
    logic              image_done;
    err_t              error_code;
  } result_t;

endpackage

@@ rtl/rleb_fifo.sv @@
module rleb_fifo #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 2
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             flush,
  input  logic             push,
  input  logic [WIDTH-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [WIDTH-1:0] rdata,
  output logic             empty
);

  localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int CNT_W = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, wr_ptr_nxt;
  logic [PTR_W-1:0] rd_ptr_r, rd_ptr_nxt;
  logic [CNT_W-1:0] count_r, count_nxt;
  logic             do_push, do_pop;

  assign full    = (count_r == CNT_W'(DEPTH));
  assign empty   = (count_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr_r];

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    count_nxt  = count_r;
    if (do_push) begin
      wr_ptr_nxt = (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + 1'b1;
    end
    if (do_pop) begin
      rd_ptr_nxt = (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + 1'b1;
    end
    if (do_push && !do_pop) begin
      count_nxt = count_r + 1'b1;
    end else if (do_pop && !do_push) begin
      count_nxt = count_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n || flush) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= wdata;
    end
  end

endmodule

@@ rtl/rleb_front.sv @@
module rleb_front #(
  parameter int BUDGET_BITS = 24
) (
  input  logic                     clk,
  input  logic                     restart,
  input  logic                     accept,
  input  logic [7:0]               code_byte,
  input  logic [BUDGET_BITS-1:0]   budget,
  output logic                     desc_push,
  output rleb_pkg::desc_t          desc
);

  import rleb_pkg::*;

  phase_t                 phase_r, phase_nxt;
  logic [BYTE_W-1:0]      held_r, held_nxt;
  logic [BUDGET_BITS-1:0] used_r, used_nxt;
  logic                   halt_r, halt_nxt;

  always_comb begin
    phase_nxt       = phase_r;
    held_nxt        = held_r;
    used_nxt        = used_r;
    halt_nxt        = halt_r;
    desc_push       = 1'b0;
    desc.budget_err = 1'b0;
    desc.value      = code_byte;
    desc.len        = SINGLE_LEN;
    if (restart) begin
      phase_nxt = PH_IDLE;
      held_nxt  = '0;
      used_nxt  = '0;
      halt_nxt  = 1'b0;
    end else if (accept && !halt_r) begin
      if (used_r >= budget) begin
        desc.budget_err = 1'b1;
        desc_push       = 1'b1;
        halt_nxt        = 1'b1;
      end else begin
        used_nxt  = used_r + 1'b1;
        phase_nxt = PH_IDLE;
        unique case (phase_r)
          PH_COUNT: begin
            if (code_byte == ESC_BYTE) begin
              desc_push = 1'b1;
            end else begin
              held_nxt  = code_byte;
              phase_nxt = PH_VALUE;
            end
          end
          PH_VALUE: begin
            desc_push = 1'b1;
            desc.len  = {1'b0, held_r} + ((code_byte == ESC_BYTE) ? ESC_RUN_BIAS : RUN_BIAS);
          end
          default: begin
            if (code_byte == ESC_BYTE) begin
              phase_nxt = PH_COUNT;
            end else begin
              desc_push = 1'b1;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    phase_r <= phase_nxt;
    used_r  <= used_nxt;
    halt_r  <= halt_nxt;
    held_r  <= held_nxt;
  end

endmodule

@@ rtl/rleb_back.sv @@
module rleb_back (
  input  logic              clk,
  input  logic              restart,
  input  rleb_pkg::geom_t   geom,
  input  rleb_pkg::geom_t   geom_nxt,
  input  logic              desc_valid,
  input  rleb_pkg::desc_t   desc,
  output logic              desc_pop,
  input  logic              res_full,
  output logic              res_push,
  output rleb_pkg::result_t res
);

  import rleb_pkg::*;

  logic [ROWS_W-1:0] rows_left_r, rows_left_nxt;
  logic [COLS_W-1:0] cols_left_r, cols_left_nxt;
  logic [ADDR_W-1:0] addr_r, addr_nxt;
  logic              halt_r, halt_nxt;
  logic [COLS_W-1:0] cols_rem;
  logic [ROWS_W-1:0] rows_dec;
  logic [ADDR_W-1:0] addr_step;
  logic [ADDR_W-1:0] skip;

  assign skip      = ADDR_W'(geom.stride) - ADDR_W'(geom.cols);
  assign cols_rem  = cols_left_r - COLS_W'(desc.len);
  assign addr_step = addr_r + ADDR_W'(desc.len);
  assign rows_dec  = (rows_left_r != '0) ? rows_left_r - 1'b1 : rows_left_r;
  assign desc_pop  = desc_valid && !res_full && !restart;

  always_comb begin
    rows_left_nxt     = rows_left_r;
    cols_left_nxt     = cols_left_r;
    addr_nxt          = addr_r;
    halt_nxt          = halt_r;
    res_push          = 1'b0;
    res.pixel_value   = desc.value;
    res.run_length    = '0;
    res.start_address = addr_r;
    res.row_done      = 1'b0;
    res.image_done    = 1'b0;
    res.error_code    = ERR_NONE;
    if (restart) begin
      rows_left_nxt = geom_nxt.rows;
      cols_left_nxt = geom_nxt.cols;
      addr_nxt      = '0;
      halt_nxt      = (geom_nxt.rows == '0) || (geom_nxt.cols == '0);
    end else if (desc_pop && !halt_r) begin
      res_push = 1'b1;
      priority if (desc.budget_err) begin
        res.pixel_value = '0;
        res.error_code  = ERR_BUDGET;
        halt_nxt        = 1'b1;
      end else if (COLS_W'(desc.len) > cols_left_r || (desc.len >> COLS_W) != '0) begin
        res.error_code = ERR_RUN;
        halt_nxt       = 1'b1;
      end else begin
        res.run_length = desc.len;
        if (cols_rem == '0) begin
          res.row_done  = 1'b1;
          addr_nxt      = addr_step + skip;
          cols_left_nxt = geom.cols;
          rows_left_nxt = rows_dec;
          if (rows_dec == '0) begin
            res.image_done = 1'b1;
            halt_nxt       = 1'b1;
          end
        end else begin
          cols_left_nxt = cols_rem;
          addr_nxt      = addr_step;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    rows_left_r <= rows_left_nxt;
    cols_left_r <= cols_left_nxt;
    addr_r      <= addr_nxt;
    halt_r      <= halt_nxt;
  end

endmodule

@@ rtl/rle_escape_byte_decoder.sv @@
// Channel  Direction  Handshake               Payload
// input    in         in_push / in_full       in_code_byte
// result   out        out_pop / out_empty     out_pixel_value .. out_error_code
// config   in         cfg_wen, no wait        cfg_index, cfg_wdata
//
// One byte a cycle is taken while in_full is low; the parser hands runs to the address unit
// through a four-entry queue, and the address unit retires one run a cycle, unless held by
// res_full, into a two-entry result queue. Each run is registered in both queues before output.
// in_full rises only when both queues back up behind out_pop.
// Synchronous rst_n loads rows = cols = stride = 1 and budget 0 and empties both queues;
// a write to a known register restarts decoding from the first row and also empties them.
module rle_escape_byte_decoder #(
  parameter int MAX_DIM     = 4096,
  parameter int MAX_STRIDE  = 8192,
  parameter int BUDGET_BITS = 24
) (
  input  logic                                   clk,
  input  logic                                   rst_n,
  input  logic                                   cfg_wen,
  input  logic [rleb_pkg::CFG_IDX_W-1:0]         cfg_index,
  input  logic [rleb_pkg::CFG_DATA_W-1:0]        cfg_wdata,
  input  logic                                   in_push,
  output logic                                   in_full,
  input  logic [7:0]                             in_code_byte,
  output logic                                   out_empty,
  input  logic                                   out_pop,
  output logic [7:0]                             out_pixel_value,
  output logic [8:0]                             out_run_length,
  output logic [24:0]                            out_start_address,
  output logic                                   out_row_done,
  output logic                                   out_image_done,
  output logic [1:0]                             out_error_code
);

  import rleb_pkg::*;

  localparam int BUDGET_IN_W = (BUDGET_BITS < CFG_DATA_W) ? BUDGET_BITS : CFG_DATA_W;
  localparam int DESC_DEPTH  = 4;
  localparam int RES_DEPTH   = 2;

  geom_t                  geom_r, geom_nxt;
  logic [BUDGET_BITS-1:0] budget_r, budget_nxt;
  logic                   cfg_hit;
  logic                   restart;
  logic                   accept;
  logic                   desc_push, desc_pop, desc_empty, res_push, res_full;
  desc_t                  desc_in, desc_out;
  result_t                res_in, res_out;

  always_comb begin
    geom_nxt   = geom_r;
    budget_nxt = budget_r;
    cfg_hit    = 1'b0;
    if (!rst_n) begin
      geom_nxt.rows   = ROWS_W'(1);
      geom_nxt.cols   = COLS_W'(1);
      geom_nxt.stride = STRIDE_W'(1);
      budget_nxt      = '0;
    end else if (cfg_wen) begin
      unique case (cfg_reg_t'(cfg_index))
        REG_ROWS: begin
          geom_nxt.rows = (32'(cfg_wdata[ROWS_W-1:0]) > MAX_DIM) ?
                          ROWS_W'(MAX_DIM) : cfg_wdata[ROWS_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_COLS: begin
          geom_nxt.cols = (32'(cfg_wdata[COLS_W-1:0]) > MAX_DIM) ?
                          COLS_W'(MAX_DIM) : cfg_wdata[COLS_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_STRIDE: begin
          geom_nxt.stride = (32'(cfg_wdata[STRIDE_W-1:0]) > MAX_STRIDE) ?
                            STRIDE_W'(MAX_STRIDE) : cfg_wdata[STRIDE_W-1:0];
          cfg_hit = 1'b1;
        end
        REG_BUDGET: begin
          budget_nxt = BUDGET_BITS'(cfg_wdata[BUDGET_IN_W-1:0]);
          cfg_hit    = 1'b1;
        end
        default: ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    geom_r   <= geom_nxt;
    budget_r <= budget_nxt;
  end

  assign restart = !rst_n || cfg_hit;
  assign accept  = in_push && !in_full;

  rleb_front #(
    .BUDGET_BITS(BUDGET_BITS)
  ) u_front (
    .clk       (clk),
    .restart   (restart),
    .accept    (accept),
    .code_byte (in_code_byte),
    .budget    (budget_r),
    .desc_push (desc_push),
    .desc      (desc_in)
  );

  rleb_fifo #(
    .WIDTH($bits(desc_t)),
    .DEPTH(DESC_DEPTH)
  ) u_desc_q (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (cfg_hit),
    .push  (desc_push),
    .wdata (desc_in),
    .full  (in_full),
    .pop   (desc_pop),
    .rdata (desc_out),
    .empty (desc_empty)
  );

  rleb_back u_back (
    .clk        (clk),
    .restart    (restart),
    .geom       (geom_r),
    .geom_nxt   (geom_nxt),
    .desc_valid (!desc_empty),
    .desc       (desc_out),
    .desc_pop   (desc_pop),
    .res_full   (res_full),
    .res_push   (res_push),
    .res        (res_in)
  );

  rleb_fifo #(
    .WIDTH($bits(result_t)),
    .DEPTH(RES_DEPTH)
  ) u_res_q (
    .clk   (clk),
    .rst_n (rst_n),
    .flush (cfg_hit),
    .push  (res_push),
    .wdata (res_in),
    .full  (res_full),
    .pop   (out_pop),
    .rdata (res_out),
    .empty (out_empty)
  );

  assign out_pixel_value   = res_out.pixel_value;
  assign out_run_length    = res_out.run_length;
  assign out_start_address = res_out.start_address;
  assign out_row_done      = res_out.row_done;
  assign out_image_done    = res_out.image_done;
  assign out_error_code    = res_out.error_code;

`ifndef SYNTHESIS
  a_err_zero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error_code != ERR_NONE) |-> (out_run_length == '0))
    else $error("error beat carries a run length");

  a_ok_nonzero_len: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_error_code == ERR_NONE) |-> (out_run_length != '0))
    else $error("good beat with zero run length");

  a_image_ends_row: assert property (@(posedge clk) disable iff (!rst_n)
    (!out_empty && out_image_done) |-> (out_row_done && out_error_code == ERR_NONE))
    else $error("image end without row end");

  a_restart_flush: assert property (@(posedge clk) disable iff (!rst_n)
    cfg_hit |=> (out_empty && !in_full))
    else $error("queues not emptied by register write");
`endif

endmodule
